/* sv/ssb_pkg.sv */
// ----------------------------------------------------------------------------
// ssb_pkg
// Shared widths and result type of the stack sequence builder.
// ----------------------------------------------------------------------------
package ssb_pkg;

	localparam int FIELD_W = 11;
	localparam int NEXT_W  = FIELD_W + 1;

	typedef struct packed {
		logic [FIELD_W-1:0] push_count;
		logic               popped;
		logic               failed;
		logic               sequence_done;
	} ssb_result_t;

endpackage

/* sv/ssb_stack_ram.sv */
// ----------------------------------------------------------------------------
// ssb_stack_ram
// Stack storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ssb_stack_ram #(
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [ADDR_W-1:0]           waddr,
	input  logic [ssb_pkg::FIELD_W-1:0] wdata,
	input  logic                        re,
	input  logic [ADDR_W-1:0]           raddr,
	output logic [ssb_pkg::FIELD_W-1:0] rdata
);

	logic [ssb_pkg::FIELD_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* sv/ssb_seq.sv */
// ----------------------------------------------------------------------------
// ssb_seq
// Sequencer: one push per cycle, then a compare and either a pop with top-of-stack refill or a fail.
// ----------------------------------------------------------------------------
module ssb_seq #(
	parameter int MAX_LEN = 1024,
	parameter int ADDR_W  = $clog2(MAX_LEN),
	parameter int DEPTH_W = $clog2(MAX_LEN + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [ssb_pkg::FIELD_W-1:0] cfg_len,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  logic [ssb_pkg::FIELD_W-1:0] req_target,
	output logic                        res_valid,
	input  logic                        res_ready,
	output ssb_pkg::ssb_result_t        res,
	output logic                        mem_we,
	output logic [ADDR_W-1:0]           mem_waddr,
	output logic [ssb_pkg::FIELD_W-1:0] mem_wdata,
	output logic                        mem_re,
	output logic [ADDR_W-1:0]           mem_raddr,
	input  logic [ssb_pkg::FIELD_W-1:0] mem_rdata
);

	localparam int LIM = (MAX_LEN < 2047) ? MAX_LEN : 2047;
	localparam logic [ssb_pkg::FIELD_W-1:0] LIM_V = ssb_pkg::FIELD_W'(LIM);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PUSH,
		ST_REFILL,
		ST_RESULT
	} state_t;

	state_t                       state_q;
	logic [ssb_pkg::FIELD_W-1:0]  len_q;
	logic [ssb_pkg::FIELD_W-1:0]  target_q;
	logic [ssb_pkg::FIELD_W-1:0]  top_q;
	logic [DEPTH_W-1:0]           depth_q;
	logic [ssb_pkg::NEXT_W-1:0]   next_q;
	logic [ssb_pkg::FIELD_W-1:0]  matched_q;
	logic                         fail_q;
	ssb_pkg::ssb_result_t         res_q;

	logic                         empty;
	logic                         top_lt;
	logic                         top_eq;
	logic                         can_push;
	logic                         push_go;
	logic [ssb_pkg::FIELD_W-1:0]  matched_inc;

	assign empty       = (depth_q == '0);
	assign top_lt      = (top_q < target_q);
	assign top_eq      = (top_q == target_q);
	assign can_push    = (next_q <= {1'b0, len_q});
	assign push_go     = (state_q == ST_PUSH) && (empty || top_lt) && can_push;
	assign matched_inc = matched_q + ssb_pkg::FIELD_W'(1);

	assign mem_we    = push_go;
	assign mem_waddr = depth_q[ADDR_W-1:0];
	assign mem_wdata = next_q[ssb_pkg::FIELD_W-1:0];
	assign mem_re    = (state_q == ST_PUSH) && !push_go && !empty && top_eq;
	assign mem_raddr = ADDR_W'(depth_q - DEPTH_W'(2));

	assign req_stall = (state_q != ST_IDLE);
	assign res_valid = (state_q == ST_RESULT);
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			len_q     <= ssb_pkg::FIELD_W'(1);
			depth_q   <= '0;
			next_q    <= ssb_pkg::NEXT_W'(1);
			matched_q <= '0;
			fail_q    <= 1'b0;
		end else if (cfg_we) begin
			state_q   <= ST_IDLE;
			len_q     <= (cfg_len > LIM_V) ? LIM_V : cfg_len;
			depth_q   <= '0;
			next_q    <= ssb_pkg::NEXT_W'(1);
			matched_q <= '0;
			fail_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						target_q         <= req_target;
						res_q.push_count <= '0;
						res_q.popped     <= 1'b0;
						if (fail_q || matched_q >= len_q) begin
							res_q.failed        <= fail_q;
							res_q.sequence_done <= !fail_q;
							state_q             <= ST_RESULT;
						end else begin
							state_q <= ST_PUSH;
						end
					end
				end
				ST_PUSH: begin
					if (push_go) begin
						top_q            <= next_q[ssb_pkg::FIELD_W-1:0];
						depth_q          <= depth_q + DEPTH_W'(1);
						next_q           <= next_q + ssb_pkg::NEXT_W'(1);
						res_q.push_count <= res_q.push_count + ssb_pkg::FIELD_W'(1);
					end else if (!empty && top_eq) begin
						depth_q             <= depth_q - DEPTH_W'(1);
						matched_q           <= matched_inc;
						res_q.popped        <= 1'b1;
						res_q.failed        <= 1'b0;
						res_q.sequence_done <= (matched_inc >= len_q);
						state_q             <= ST_REFILL;
					end else begin
						fail_q              <= 1'b1;
						res_q.failed        <= 1'b1;
						res_q.sequence_done <= 1'b0;
						state_q             <= ST_RESULT;
					end
				end
				ST_REFILL: begin
					top_q   <= mem_rdata;
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* sv/stack_sequence_builder.sv */
// Flow: a popped target goes through the push, refill and result states and the output
// register; a failure skips refill, and a block already failed or done skips push too.
// Throughput: one request at a time, pushes one per cycle through the single stack
// write port; the next request is taken the cycle after the result enters the output
// register, and a result held there by out_stall blocks the request behind it.
// Reset: control state clears at once; stack storage is not cleared, no sweep.
// ----------------------------------------------------------------------------
// stack_sequence_builder
// Checks a target sequence against ascending pushes and pops on a stack.
// ----------------------------------------------------------------------------
module stack_sequence_builder #(
	parameter int MAX_LEN = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        seq_length_we,
	input  logic [ssb_pkg::FIELD_W-1:0] seq_length,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [ssb_pkg::FIELD_W-1:0] target_value,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [ssb_pkg::FIELD_W-1:0] push_count,
	output logic                        popped,
	output logic                        failed,
	output logic                        sequence_done
);

	localparam int ADDR_W  = $clog2(MAX_LEN);
	localparam int DEPTH_W = $clog2(MAX_LEN + 1);

	logic                        res_valid;
	logic                        res_ready;
	ssb_pkg::ssb_result_t        res;
	ssb_pkg::ssb_result_t        out_q;
	logic                        out_valid_q;
	logic                        mem_we;
	logic [ADDR_W-1:0]           mem_waddr;
	logic [ssb_pkg::FIELD_W-1:0] mem_wdata;
	logic                        mem_re;
	logic [ADDR_W-1:0]           mem_raddr;
	logic [ssb_pkg::FIELD_W-1:0] mem_rdata;

	ssb_seq #(
		.MAX_LEN (MAX_LEN),
		.ADDR_W  (ADDR_W),
		.DEPTH_W (DEPTH_W)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (seq_length_we),
		.cfg_len    (seq_length),
		.req_valid  (in_valid),
		.req_stall  (in_stall),
		.req_target (target_value),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata)
	);

	ssb_stack_ram #(
		.DEPTH  (MAX_LEN),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign push_count    = out_q.push_count;
	assign popped        = out_q.popped;
	assign failed        = out_q.failed;
	assign sequence_done = out_q.sequence_done;

endmodule
